### hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the clock sweep cache.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### hw/rtl/csc_pkg.sv
// Types and constants for the clock sweep cache.
`default_nettype none

package csc_pkg;

    // Default geometry
    localparam int DEF_NUM_FRAMES  = 16;
    localparam int DEF_KEY_WIDTH   = 32;
    localparam int DEF_VALUE_WIDTH = 32;

    // Stream field widths
    localparam int KEY_IN_W    = 32;
    localparam int VALUE_IN_W  = 32;
    localparam int READ_OUT_W  = 32;
    localparam int FRAME_OUT_W = 4;

    localparam int S_TDATA_W = KEY_IN_W + VALUE_IN_W;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    // Request kinds
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SWEEP,
        ST_GET_CAP,
        ST_EMIT
    } csc_state_t;

endpackage

`default_nettype wire

### hw/rtl/csc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module csc_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### hw/rtl/clock_sweep_cache.sv
// Clock sweep cache: fully associative key/value store with second-chance replacement.
// Input channel s_*: one request per beat. s_tuser is the kind (get or put),
// s_tdata carries the key and, for a put, the value to store.
// Output channel m_*: exactly one response per request, in request order.
// m_tuser flags hit and replacement, m_tdata carries the read value and frame.
// A request is handled by one sequencer that walks the frames with a single
// key comparator fed from the key RAM, one frame per cycle, then walks the
// clock hand one frame per cycle on a put that misses.
// The scan stops at the first hit; a get hit then captures the value RAM read
// before the response, and a miss scans all NUM_FRAMES frames, after which a
// put that misses sweeps the clock hand to a victim frame.
// s_tready is high only while the sequencer is idle, so one request is in
// flight at a time; a new request waits until the response enters the output register.
// The response sits in an output register; while the receiver stalls, the
// next request may be accepted and processed up to the point of delivery.
// Reset (aresetn low at a clock edge) clears all valid and reference bits,
// the clock hand and the output valid; key and value RAMs are not cleared.
`default_nettype none
`include "assert_macros.svh"

module clock_sweep_cache #(
    parameter int NUM_FRAMES  = csc_pkg::DEF_NUM_FRAMES,
    parameter int KEY_WIDTH   = csc_pkg::DEF_KEY_WIDTH,
    parameter int VALUE_WIDTH = csc_pkg::DEF_VALUE_WIDTH
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Request channel
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [csc_pkg::S_TDATA_W-1:0] s_tdata,  // lookup_key, write_value
    input  wire logic [csc_pkg::S_TUSER_W-1:0] s_tuser,  // operation
    // Response channel
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic      [csc_pkg::M_TDATA_W-1:0] m_tdata,  // read_value, frame_number, pad
    output logic      [csc_pkg::M_TUSER_W-1:0] m_tuser   // hit, replaced
);

    import csc_pkg::*;

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int PAD_W = M_TDATA_W - READ_OUT_W - FRAME_OUT_W;

    // Sequencer and frame status
    csc_state_t             state_reg, state_next;
    logic [CNT_W-1:0]       scan_idx_reg, scan_idx_next;
    logic                   cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]       hand_reg, hand_next;
    logic [NUM_FRAMES-1:0]  valid_reg, valid_next;
    logic [NUM_FRAMES-1:0]  ref_reg, ref_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    // Request and response payload
    logic                   op_reg, op_next;
    logic [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [VALUE_WIDTH-1:0] wval_reg, wval_next;
    logic                   res_hit_reg, res_hit_next;
    logic                   res_repl_reg, res_repl_next;
    logic [IDX_W-1:0]       res_frame_reg, res_frame_next;
    logic [VALUE_WIDTH-1:0] res_value_reg, res_value_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]   m_tuser_reg, m_tuser_next;

    // RAM ports
    logic                   key_we;
    logic [KEY_WIDTH-1:0]   key_rdata;
    logic                   val_we;
    logic [IDX_W-1:0]       val_waddr;
    logic [VALUE_WIDTH-1:0] val_rdata;

    // Field resizing
    logic [KEY_WIDTH+KEY_IN_W-1:0]      key_wide;
    logic [VALUE_WIDTH+VALUE_IN_W-1:0]  wval_wide;
    logic [READ_OUT_W+VALUE_WIDTH-1:0]  rval_wide;
    logic [FRAME_OUT_W+IDX_W-1:0]       frame_wide;
    logic [KEY_WIDTH-1:0]               key_in;
    logic [VALUE_WIDTH-1:0]             wval_in;
    logic [READ_OUT_W-1:0]              rval_out;
    logic [FRAME_OUT_W-1:0]             frame_out;

    logic                   match;
    logic                   scan_done;
    logic                   out_free;
    logic [IDX_W-1:0]       hand_inc;

    assign key_wide   = {{KEY_WIDTH{1'b0}}, s_tdata[KEY_IN_W-1:0]};
    assign wval_wide  = {{VALUE_WIDTH{1'b0}}, s_tdata[S_TDATA_W-1:KEY_IN_W]};
    assign key_in     = key_wide[KEY_WIDTH-1:0];
    assign wval_in    = wval_wide[VALUE_WIDTH-1:0];
    assign rval_wide  = {{READ_OUT_W{1'b0}}, res_value_reg};
    assign rval_out   = rval_wide[READ_OUT_W-1:0];
    assign frame_wide = {{FRAME_OUT_W{1'b0}}, res_frame_reg};
    assign frame_out  = frame_wide[FRAME_OUT_W-1:0];

    // Shared key comparator on the frame read last cycle
    assign match     = cmp_vld_reg && valid_reg[cmp_idx_reg] && (key_rdata == key_reg);
    assign scan_done = (scan_idx_reg == CNT_W'(NUM_FRAMES));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign hand_inc  = (hand_reg == IDX_W'(NUM_FRAMES - 1)) ? '0 : hand_reg + IDX_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Key store: read by the scan, written by the sweep victim
    csc_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (NUM_FRAMES)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (key_we),
        .wr_addr (hand_reg),
        .wr_data (key_reg),
        .rd_addr (scan_idx_reg[IDX_W-1:0]),
        .rd_data (key_rdata)
    );

    // Value store: read at the compared frame, written on any put
    csc_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (NUM_FRAMES)
    ) u_val_ram (
        .aclk    (aclk),
        .wr_en   (val_we),
        .wr_addr (val_waddr),
        .wr_data (wval_reg),
        .rd_addr (cmp_idx_reg),
        .rd_data (val_rdata)
    );

    // Sequencer: next state, frame status and results
    always_comb begin
        state_next     = state_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        hand_next      = hand_reg;
        valid_next     = valid_reg;
        ref_next       = ref_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        wval_next      = wval_reg;
        res_hit_next   = res_hit_reg;
        res_repl_next  = res_repl_reg;
        res_frame_next = res_frame_reg;
        res_value_next = res_value_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        key_we         = 1'b0;
        val_we         = 1'b0;
        val_waddr      = cmp_idx_reg;

        case (state_reg)
            ST_IDLE: begin
                // Latch the request and start the scan at frame zero
                if (s_tvalid) begin
                    op_next       = s_tuser[0];
                    key_next      = key_in;
                    wval_next     = wval_in;
                    scan_idx_next = '0;
                    cmp_vld_next  = 1'b0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // Issue the next key read and compare the previous one
                cmp_vld_next = !scan_done;
                cmp_idx_next = scan_idx_reg[IDX_W-1:0];
                if (!scan_done) begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (match) begin
                    res_hit_next          = 1'b1;
                    res_repl_next         = 1'b0;
                    res_frame_next        = cmp_idx_reg;
                    res_value_next        = '0;
                    ref_next[cmp_idx_reg] = 1'b1;
                    if (op_reg == OP_PUT) begin
                        val_we     = 1'b1;
                        val_waddr  = cmp_idx_reg;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_GET_CAP;
                    end
                end else if (scan_done) begin
                    res_hit_next   = 1'b0;
                    res_repl_next  = 1'b0;
                    res_frame_next = '0;
                    res_value_next = '0;
                    state_next     = (op_reg == OP_PUT) ? ST_SWEEP : ST_EMIT;
                end
            end
            ST_GET_CAP: begin
                // Take the value read at the hit frame
                res_value_next = val_rdata;
                state_next     = ST_EMIT;
            end
            ST_SWEEP: begin
                // Give a referenced frame a second chance, else load it
                if (valid_reg[hand_reg] && ref_reg[hand_reg]) begin
                    ref_next[hand_reg] = 1'b0;
                    hand_next          = hand_inc;
                end else begin
                    key_we               = 1'b1;
                    val_we               = 1'b1;
                    val_waddr            = hand_reg;
                    res_repl_next        = valid_reg[hand_reg];
                    res_frame_next       = hand_reg;
                    valid_next[hand_reg] = 1'b1;
                    ref_next[hand_reg]   = 1'b1;
                    hand_next            = hand_inc;
                    state_next           = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hand the response to the output register once it is free
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, frame_out, rval_out};
                    m_tuser_next  = {res_repl_reg, res_hit_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            scan_idx_reg <= '0;
            cmp_vld_reg  <= 1'b0;
            hand_reg     <= '0;
            valid_reg    <= '0;
            ref_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            cmp_vld_reg  <= cmp_vld_next;
            hand_reg     <= hand_next;
            valid_reg    <= valid_next;
            ref_reg      <= ref_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmp_idx_reg   <= cmp_idx_next;
        op_reg        <= op_next;
        key_reg       <= key_next;
        wval_reg      <= wval_next;
        res_hit_reg   <= res_hit_next;
        res_repl_reg  <= res_repl_next;
        res_frame_reg <= res_frame_next;
        res_value_reg <= res_value_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    // A reference bit is only ever set on a resident frame
    `ASSERT_ALWAYS(a_ref_needs_valid, aclk, aresetn, ((ref_reg & ~valid_reg) == '0), "reference bit set on empty frame")
    // The clock hand stays inside the frame range
    `ASSERT_ALWAYS(a_hand_range, aclk, aresetn, (hand_reg <= IDX_W'(NUM_FRAMES - 1)), "clock hand out of range")
    // The last scan step always has a frame to compare
    `ASSERT_IMPLY(a_scan_tail, aclk, aresetn, (state_reg == ST_SCAN && scan_done), cmp_vld_reg, "scan ended without a final compare")

endmodule

`default_nettype wire
